>>> rtl/text_box_glyph_layout_defines.svh
// Assertion macros for the text box glyph layout block.
// Every macro samples on clock and is disabled during reset.
`ifndef TEXT_BOX_GLYPH_LAYOUT_DEFINES_SVH
`define TEXT_BOX_GLYPH_LAYOUT_DEFINES_SVH

`ifndef SYNTHESIS

`define TBGL_ASSERT(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed: expr");

`define TBGL_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: ante |-> cons");

`define TBGL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: ante |=> cons");

`else

`define TBGL_ASSERT(label, expr)
`define TBGL_ASSERT_IMPLIES(label, ante, cons)
`define TBGL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/tbgl_pkg.sv
`default_nettype none

package tbgl_pkg;

   // glyph cell geometry
   localparam int GLYPH_WIDTH  = 8;
   localparam int GLYPH_HEIGHT = 8;
   localparam int KERN_GAP     = 1;
   localparam int PAD_LEFT     = 2;
   localparam int PAD_TOP      = 2;

   localparam int PITCH_X = GLYPH_WIDTH + KERN_GAP;
   localparam int PITCH_Y = GLYPH_HEIGHT + KERN_GAP;

   localparam int COLUMN_W   = 9;
   localparam int COLUMN_MAX = (1 << COLUMN_W) - 1;
   localparam int ROW_W      = 8;
   localparam int ROW_MAX    = (1 << ROW_W) - 1;
   localparam int COUNT_W    = 16;
   localparam int ORIGIN_W   = 12;
   localparam int ORIGIN_MAX = (1 << ORIGIN_W) - 1;

   localparam int POS_W   = 13;
   localparam int POS_MAX = (1 << POS_W) - 1;

   // widest unsaturated position sums
   localparam int X_SUM_MAX = ORIGIN_MAX + PAD_LEFT + COLUMN_MAX * PITCH_X;
   localparam int Y_SUM_MAX = ORIGIN_MAX + PAD_TOP + ROW_MAX * PITCH_Y;
   localparam int X_SUM_W   = $clog2(X_SUM_MAX + 1);
   localparam int Y_SUM_W   = $clog2(Y_SUM_MAX + 1);

   // byte codes
   localparam logic [7:0] CHAR_NUL        = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CMD_BASE_COLOUR = 8'h00;
   localparam logic [7:0] CMD_SET_RGB     = 8'h01;

   // register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_COLUMNS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_ROWS    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_X    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Y    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_COLOUR = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE_BYTE = 3'd5;
   localparam int CSR_DATA_W = 24;

   // register reset values
   localparam logic [7:0]  RST_BOX_COLUMNS = 8'd32;
   localparam logic [7:0]  RST_BOX_ROWS    = 8'd8;
   localparam logic [11:0] RST_ORIGIN_X    = 12'd0;
   localparam logic [11:0] RST_ORIGIN_Y    = 12'd0;
   localparam logic [23:0] RST_BASE_COLOUR = 24'hFFFFFF;
   localparam logic [7:0]  RST_ESCAPE_BYTE = 8'd27;

   typedef enum logic [2:0] {
      ESC_NONE    = 3'd0,
      ESC_COMMAND = 3'd1,
      ESC_RED     = 3'd2,
      ESC_GREEN   = 3'd3,
      ESC_BLUE    = 3'd4
   } esc_phase_type;

   typedef struct packed {
      logic [7:0]          box_columns;
      logic [7:0]          box_rows;
      logic [ORIGIN_W-1:0] origin_x;
      logic [ORIGIN_W-1:0] origin_y;
      logic [23:0]         base_colour;
      logic [7:0]          escape_byte;
   } cfg_type;

   typedef struct packed {
      logic [7:0]       glyph_index;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [23:0]      colour;
   } glyph_type;

endpackage

`default_nettype wire

>>> rtl/text_box_glyph_layout.sv
// Text box glyph layout: takes one string byte per req item (tuser bit 0 marks
// the first byte of a string) and returns a glyph draw command for each
// printable byte, with its screen position and current tint. One item is
// accepted every cycle while req_tready is high; a command is registered into
// the output register when rsp is free, else into the skid entry. Results
// pass through this two-entry output buffer, so req_tready falls only when both
// entries hold commands that rsp has not taken. Escape sequences, control bytes
// and bytes after the end of a string produce no command. The user must write
// registers on the csr port only while idle; the block does not enforce this.
`default_nettype none

`include "text_box_glyph_layout_defines.svh"

module text_box_glyph_layout (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // req: tdata = text_byte[7:0]; tuser = string_start[0]
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [7:0]                         req_tdata,
   input  wire logic                               req_tuser,
   // rsp: tdata = glyph_index[7:0], pos_x[20:8], pos_y[33:21], colour[57:34], zero
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [63:0]                             rsp_tdata,
   input  wire logic                               csr_wr_en,
   input  wire logic [tbgl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [tbgl_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   tbgl_pkg::cfg_type   cfg_ff, cfg_in;
   tbgl_pkg::glyph_type res;
   tbgl_pkg::glyph_type out_ff, out_in;
   tbgl_pkg::glyph_type skid_ff, skid_in;
   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   logic                lay_valid;
   logic                accept;
   logic                res_valid;
   logic                out_free;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            tbgl_pkg::CSR_BOX_COLUMNS: cfg_in.box_columns = csr_wr_data[7:0];
            tbgl_pkg::CSR_BOX_ROWS:    cfg_in.box_rows    = csr_wr_data[7:0];
            tbgl_pkg::CSR_ORIGIN_X:    cfg_in.origin_x    = csr_wr_data[11:0];
            tbgl_pkg::CSR_ORIGIN_Y:    cfg_in.origin_y    = csr_wr_data[11:0];
            tbgl_pkg::CSR_BASE_COLOUR: cfg_in.base_colour = csr_wr_data[23:0];
            tbgl_pkg::CSR_ESCAPE_BYTE: cfg_in.escape_byte = csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.box_columns <= tbgl_pkg::RST_BOX_COLUMNS;
         cfg_ff.box_rows    <= tbgl_pkg::RST_BOX_ROWS;
         cfg_ff.origin_x    <= tbgl_pkg::RST_ORIGIN_X;
         cfg_ff.origin_y    <= tbgl_pkg::RST_ORIGIN_Y;
         cfg_ff.base_colour <= tbgl_pkg::RST_BASE_COLOUR;
         cfg_ff.escape_byte <= tbgl_pkg::RST_ESCAPE_BYTE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   tbgl_layout u_layout (
      .clock        (clock),
      .reset        (reset),
      .step         (accept),
      .text_byte    (req_tdata),
      .string_start (req_tuser),
      .cfg          (cfg_ff),
      .result_valid (lay_valid),
      .result       (res)
   );

   assign res_valid = accept && lay_valid;
   assign out_free  = !out_valid_ff || rsp_tready;

   // output register plus skid entry; skid only fills while rsp stalls
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = res_valid;
         end
      end else if (res_valid) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff.colour, out_ff.pos_y, out_ff.pos_x, out_ff.glyph_index};

   `TBGL_ASSERT(a_skid_needs_out, !skid_valid_ff || out_valid_ff)
   `TBGL_ASSERT_NEXT(a_skid_drains, skid_valid_ff && rsp_tready, out_valid_ff)
   `TBGL_ASSERT_NEXT(a_result_lands, res_valid && !out_valid_ff, out_valid_ff && !skid_valid_ff)

endmodule

`default_nettype wire

>>> rtl/tbgl_layout.sv
`default_nettype none

`include "text_box_glyph_layout_defines.svh"

module tbgl_layout (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [7:0]          text_byte,
   input  wire logic                string_start,
   input  wire tbgl_pkg::cfg_type   cfg,
   output logic                     result_valid,
   output tbgl_pkg::glyph_type      result
);

   logic [tbgl_pkg::COLUMN_W-1:0] column_ff, column_in;
   logic [tbgl_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [tbgl_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                          finished_ff, finished_in;
   tbgl_pkg::esc_phase_type       phase_ff, phase_in;
   logic [7:0]                    red_ff, red_in;
   logic [7:0]                    green_ff, green_in;
   logic [23:0]                   tint_ff, tint_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff   <= '0;
         row_ff      <= '0;
         count_ff    <= '0;
         finished_ff <= 1'b0;
         phase_ff    <= tbgl_pkg::ESC_NONE;
         red_ff      <= '0;
         green_ff    <= '0;
         tint_ff     <= tbgl_pkg::RST_BASE_COLOUR;
      end else begin
         column_ff   <= column_in;
         row_ff      <= row_in;
         count_ff    <= count_in;
         finished_ff <= finished_in;
         phase_ff    <= phase_in;
         red_ff      <= red_in;
         green_ff    <= green_in;
         tint_ff     <= tint_in;
      end
   end

   always_comb begin
      logic [tbgl_pkg::COLUMN_W-1:0] col0;
      logic [tbgl_pkg::ROW_W-1:0]    row0;
      logic [tbgl_pkg::COUNT_W-1:0]  cnt0;
      logic [tbgl_pkg::COUNT_W-1:0]  cnt_inc;
      logic [tbgl_pkg::COUNT_W-1:0]  limit;
      logic                          fin0;
      tbgl_pkg::esc_phase_type       ph0;
      logic [tbgl_pkg::ROW_W:0]      row_plus;
      logic                          last_row;
      logic                          col_over;
      logic [tbgl_pkg::COLUMN_W-1:0] col1;
      logic [tbgl_pkg::ROW_W-1:0]    row1;
      logic [tbgl_pkg::X_SUM_W-1:0]  x_sum;
      logic [tbgl_pkg::Y_SUM_W-1:0]  y_sum;

      // a new string clears the layout before this byte is handled
      col0 = string_start ? '0 : column_ff;
      row0 = string_start ? '0 : row_ff;
      cnt0 = string_start ? '0 : count_ff;
      fin0 = string_start ? 1'b0 : finished_ff;
      ph0  = string_start ? tbgl_pkg::ESC_NONE : phase_ff;

      cnt_inc  = (cnt0 == '1) ? cnt0 : cnt0 + 1'b1;
      limit    = tbgl_pkg::COUNT_W'(cfg.box_columns) * tbgl_pkg::COUNT_W'(cfg.box_rows);
      row_plus = {1'b0, row0} + 1'b1;
      last_row = row_plus >= {1'b0, cfg.box_rows};
      col_over = col0 >= {1'b0, cfg.box_columns};

      col1 = col0;
      row1 = row0;
      if (!last_row && (text_byte == tbgl_pkg::CHAR_NEWLINE || col_over)) begin
         col1 = '0;
         row1 = row_plus[tbgl_pkg::ROW_W-1:0];
      end

      x_sum = tbgl_pkg::X_SUM_W'(cfg.origin_x) + tbgl_pkg::X_SUM_W'(tbgl_pkg::PAD_LEFT)
            + tbgl_pkg::X_SUM_W'(col1) * tbgl_pkg::X_SUM_W'(tbgl_pkg::PITCH_X);
      y_sum = tbgl_pkg::Y_SUM_W'(cfg.origin_y) + tbgl_pkg::Y_SUM_W'(tbgl_pkg::PAD_TOP)
            + tbgl_pkg::Y_SUM_W'(row1) * tbgl_pkg::Y_SUM_W'(tbgl_pkg::PITCH_Y);

      result.glyph_index = text_byte - tbgl_pkg::CHAR_SPACE;
      result.pos_x = (x_sum > tbgl_pkg::X_SUM_W'(tbgl_pkg::POS_MAX))
                   ? tbgl_pkg::POS_W'(tbgl_pkg::POS_MAX) : x_sum[tbgl_pkg::POS_W-1:0];
      result.pos_y = (y_sum > tbgl_pkg::Y_SUM_W'(tbgl_pkg::POS_MAX))
                   ? tbgl_pkg::POS_W'(tbgl_pkg::POS_MAX) : y_sum[tbgl_pkg::POS_W-1:0];
      result.colour = tint_ff;

      column_in    = column_ff;
      row_in       = row_ff;
      count_in     = count_ff;
      finished_in  = finished_ff;
      phase_in     = phase_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      tint_in      = tint_ff;
      result_valid = 1'b0;

      if (step) begin
         column_in   = col0;
         row_in      = row0;
         count_in    = cnt0;
         finished_in = fin0;
         phase_in    = ph0;
         if (fin0) begin
            // string over: byte dropped
         end else if (ph0 != tbgl_pkg::ESC_NONE) begin
            count_in = cnt_inc;
            unique case (ph0)
               tbgl_pkg::ESC_COMMAND: begin
                  if (text_byte == tbgl_pkg::CMD_BASE_COLOUR) begin
                     tint_in  = cfg.base_colour;
                     phase_in = tbgl_pkg::ESC_NONE;
                  end else if (text_byte == tbgl_pkg::CMD_SET_RGB) begin
                     phase_in = tbgl_pkg::ESC_RED;
                  end else begin
                     phase_in = tbgl_pkg::ESC_NONE;
                  end
               end
               tbgl_pkg::ESC_RED: begin
                  red_in   = text_byte;
                  phase_in = tbgl_pkg::ESC_GREEN;
               end
               tbgl_pkg::ESC_GREEN: begin
                  green_in = text_byte;
                  phase_in = tbgl_pkg::ESC_BLUE;
               end
               default: begin
                  tint_in  = {red_ff, green_ff, text_byte};
                  phase_in = tbgl_pkg::ESC_NONE;
               end
            endcase
         end else if (cnt0 >= limit || text_byte == tbgl_pkg::CHAR_NUL) begin
            finished_in = 1'b1;
         end else begin
            count_in = cnt_inc;
            if (text_byte == cfg.escape_byte) begin
               phase_in = tbgl_pkg::ESC_COMMAND;
            end else if (last_row && col_over) begin
               finished_in = 1'b1;
            end else begin
               row_in    = row1;
               column_in = col1;
               if (text_byte >= tbgl_pkg::CHAR_SPACE) begin
                  result_valid = 1'b1;
                  if (col1 != tbgl_pkg::COLUMN_W'(tbgl_pkg::COLUMN_MAX)) begin
                     column_in = col1 + 1'b1;
                  end
               end
            end
         end
      end
   end

   `TBGL_ASSERT_IMPLIES(a_done_silent, finished_ff && !string_start, !result_valid)
   `TBGL_ASSERT_IMPLIES(a_escape_silent, phase_ff != tbgl_pkg::ESC_NONE && !string_start, !result_valid)
   `TBGL_ASSERT_NEXT(a_count_monotone, !(step && string_start), count_ff >= $past(count_ff))

endmodule

`default_nettype wire

>>> sim/testbench.sv
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 1250;
   localparam int SETTLE       = 4;

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_tvalid  = 1'b0;
   logic                             req_tready;
   logic [7:0]                       req_tdata   = '0;
   logic                             req_tuser   = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready  = 1'b0;
   logic [63:0]                      rsp_tdata;
   logic                             csr_wr_en   = 1'b0;
   logic [tbgl_pkg::CSR_INDEX_W-1:0] csr_index   = '0;
   logic [tbgl_pkg::CSR_DATA_W-1:0]  csr_wr_data = '0;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int error_count = 0;
   int cycle_count = 0;
   int sent_items  = 0;

   // layout state kept alongside the block
   tbgl_pkg::cfg_type             box_cfg;
   logic [tbgl_pkg::COLUMN_W-1:0] cur_column;
   logic [tbgl_pkg::ROW_W-1:0]    cur_row;
   logic [tbgl_pkg::COUNT_W-1:0]  byte_total;
   bit                            string_done;
   tbgl_pkg::esc_phase_type       esc_phase;
   logic [7:0]                    held_red;
   logic [7:0]                    held_green;
   logic [23:0]                   cur_tint;

   tbgl_pkg::glyph_type pending_glyphs[$];

   text_box_glyph_layout uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   task automatic report_error(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      tbgl_pkg::glyph_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_glyphs.size() == 0) begin
            report_error($sformatf("unexpected glyph command %h", rsp_tdata));
         end else begin
            want = pending_glyphs.pop_front();
            if (rsp_tdata[7:0] !== want.glyph_index)
               report_error($sformatf("glyph_index %h, want %h",
                                      rsp_tdata[7:0], want.glyph_index));
            if (rsp_tdata[20:8] !== want.pos_x)
               report_error($sformatf("pos_x %0d, want %0d", rsp_tdata[20:8], want.pos_x));
            if (rsp_tdata[33:21] !== want.pos_y)
               report_error($sformatf("pos_y %0d, want %0d", rsp_tdata[33:21], want.pos_y));
            if (rsp_tdata[57:34] !== want.colour)
               report_error($sformatf("colour %h, want %h", rsp_tdata[57:34], want.colour));
            if (rsp_tdata[63:58] !== '0)
               report_error($sformatf("padding bits %b", rsp_tdata[63:58]));
         end
      end
   end

   // advances the layout by one accepted byte
   task automatic layout_byte(input logic [7:0] ch, input logic first);
      int                  limit;
      int                  px;
      int                  py;
      bit                  last_row;
      tbgl_pkg::glyph_type g;
      if (first) begin
         cur_column  = '0;
         cur_row     = '0;
         byte_total  = '0;
         string_done = 1'b0;
         esc_phase   = tbgl_pkg::ESC_NONE;
      end
      if (string_done) return;
      limit = int'(box_cfg.box_columns) * int'(box_cfg.box_rows);
      // bytes inside an escape sequence are plain data
      if (esc_phase != tbgl_pkg::ESC_NONE) begin
         case (esc_phase)
            tbgl_pkg::ESC_COMMAND: begin
               if (ch == tbgl_pkg::CMD_BASE_COLOUR) begin
                  cur_tint  = box_cfg.base_colour;
                  esc_phase = tbgl_pkg::ESC_NONE;
               end else if (ch == tbgl_pkg::CMD_SET_RGB) begin
                  esc_phase = tbgl_pkg::ESC_RED;
               end else begin
                  esc_phase = tbgl_pkg::ESC_NONE;
               end
            end
            tbgl_pkg::ESC_RED: begin
               held_red  = ch;
               esc_phase = tbgl_pkg::ESC_GREEN;
            end
            tbgl_pkg::ESC_GREEN: begin
               held_green = ch;
               esc_phase  = tbgl_pkg::ESC_BLUE;
            end
            default: begin
               cur_tint  = {held_red, held_green, ch};
               esc_phase = tbgl_pkg::ESC_NONE;
            end
         endcase
         if (byte_total != '1) byte_total++;
         return;
      end
      if (int'(byte_total) >= limit || ch == tbgl_pkg::CHAR_NUL) begin
         string_done = 1'b1;
         return;
      end
      if (byte_total != '1) byte_total++;
      if (ch == box_cfg.escape_byte) begin
         esc_phase = tbgl_pkg::ESC_COMMAND;
         return;
      end
      last_row = (int'(cur_row) + 1) >= int'(box_cfg.box_rows);
      if (last_row && cur_column >= box_cfg.box_columns) begin
         string_done = 1'b1;
         return;
      end
      if (!last_row && (ch == tbgl_pkg::CHAR_NEWLINE || cur_column >= box_cfg.box_columns))
      begin
         cur_column = '0;
         cur_row++;
      end
      if (ch < tbgl_pkg::CHAR_SPACE) return;
      px = int'(box_cfg.origin_x) + tbgl_pkg::PAD_LEFT + int'(cur_column) * tbgl_pkg::PITCH_X;
      py = int'(box_cfg.origin_y) + tbgl_pkg::PAD_TOP + int'(cur_row) * tbgl_pkg::PITCH_Y;
      g.glyph_index = ch - tbgl_pkg::CHAR_SPACE;
      g.pos_x       = (px > tbgl_pkg::POS_MAX) ? tbgl_pkg::POS_W'(tbgl_pkg::POS_MAX)
                                               : tbgl_pkg::POS_W'(px);
      g.pos_y       = (py > tbgl_pkg::POS_MAX) ? tbgl_pkg::POS_W'(tbgl_pkg::POS_MAX)
                                               : tbgl_pkg::POS_W'(py);
      g.colour      = cur_tint;
      pending_glyphs.push_back(g);
      if (cur_column != tbgl_pkg::COLUMN_MAX) cur_column++;
   endtask

   task automatic send_byte(input logic [7:0] ch, input logic first);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      layout_byte(ch, first);
      sent_items++;
   endtask

   // hold off the sender until every glyph has come out and the block settles
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_glyphs.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_register(input logic [tbgl_pkg::CSR_INDEX_W-1:0] index,
                               input logic [tbgl_pkg::CSR_DATA_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         tbgl_pkg::CSR_BOX_COLUMNS: box_cfg.box_columns = value[7:0];
         tbgl_pkg::CSR_BOX_ROWS:    box_cfg.box_rows    = value[7:0];
         tbgl_pkg::CSR_ORIGIN_X:    box_cfg.origin_x    = value[tbgl_pkg::ORIGIN_W-1:0];
         tbgl_pkg::CSR_ORIGIN_Y:    box_cfg.origin_y    = value[tbgl_pkg::ORIGIN_W-1:0];
         tbgl_pkg::CSR_BASE_COLOUR: box_cfg.base_colour = value[23:0];
         tbgl_pkg::CSR_ESCAPE_BYTE: box_cfg.escape_byte = value[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic test_printable_and_control();
      send_byte("H", 1'b1);
      send_byte(tbgl_pkg::CHAR_SPACE, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(tbgl_pkg::CHAR_NEWLINE, 1'b0);
      send_byte(8'h07, 1'b0);
      send_byte("e", 1'b0);
      send_byte(tbgl_pkg::CHAR_NUL, 1'b0);
      send_byte("x", 1'b0);            // after the end: ignored
   endtask

   task automatic test_escape_sequences();
      send_byte(tbgl_pkg::RST_ESCAPE_BYTE, 1'b1);
      send_byte(tbgl_pkg::CMD_SET_RGB, 1'b0);
      send_byte(tbgl_pkg::CHAR_NUL, 1'b0);        // red byte, not an end
      send_byte(tbgl_pkg::RST_ESCAPE_BYTE, 1'b0); // green byte, not an escape
      send_byte(8'h80, 1'b0);
      send_byte("A", 1'b0);
      send_byte(tbgl_pkg::RST_ESCAPE_BYTE, 1'b0);
      send_byte(tbgl_pkg::CMD_BASE_COLOUR, 1'b0);
      send_byte(tbgl_pkg::RST_ESCAPE_BYTE, 1'b0);
      send_byte(8'h05, 1'b0);          // unknown command is skipped
      send_byte("B", 1'b0);
   endtask

   task automatic test_box_edges();
      wait_idle();
      set_register(tbgl_pkg::CSR_BOX_COLUMNS, 24'd2);
      set_register(tbgl_pkg::CSR_BOX_ROWS, 24'd2);
      set_register(tbgl_pkg::CSR_ORIGIN_X, 24'hFFF);
      set_register(tbgl_pkg::CSR_ORIGIN_Y, 24'hFFF);
      set_register(tbgl_pkg::CSR_BASE_COLOUR, 24'h000000);
      set_register(tbgl_pkg::CSR_ESCAPE_BYTE, {16'd0, 8'h41});
      // wraps after two columns, printable escape, then the byte limit ends it
      send_byte("x", 1'b1);
      send_byte("y", 1'b0);
      send_byte("z", 1'b0);
      send_byte("A", 1'b0);
      send_byte(tbgl_pkg::CMD_BASE_COLOUR, 1'b0);
      send_byte("q", 1'b0);
      wait_idle();
      set_register(tbgl_pkg::CSR_BOX_COLUMNS, 24'd1);
      set_register(tbgl_pkg::CSR_BOX_ROWS, 24'd1);
      send_byte("a", 1'b1);
      send_byte("b", 1'b0);            // overflow on the last row
      wait_idle();
      set_register(tbgl_pkg::CSR_BOX_COLUMNS, 24'd255);
      set_register(tbgl_pkg::CSR_BOX_ROWS, 24'd255);
      send_byte("m", 1'b1);
      wait_idle();
      set_register(tbgl_pkg::CSR_ORIGIN_X, 24'd0); // mid-string change
      send_byte("n", 1'b0);
      wait_idle();
      set_register(tbgl_pkg::CSR_BOX_COLUMNS, 24'd0);
      send_byte("a", 1'b1);            // empty box ends at once
      wait_idle();
   endtask

   task automatic random_setup();
      logic [7:0] cols;
      logic [7:0] rows;
      case ($urandom_range(9))
         0:       cols = 8'd0;
         1:       cols = 8'd255;
         2, 3, 4: cols = 8'($urandom_range(1, 4));
         default: cols = 8'($urandom_range(5, 40));
      endcase
      case ($urandom_range(9))
         0:       rows = ($urandom_range(3) == 0) ? 8'd0 : 8'd255;
         1, 2, 3: rows = 8'($urandom_range(1, 3));
         default: rows = 8'($urandom_range(4, 20));
      endcase
      set_register(tbgl_pkg::CSR_BOX_COLUMNS, {16'd0, cols});
      set_register(tbgl_pkg::CSR_BOX_ROWS, {16'd0, rows});
      set_register(tbgl_pkg::CSR_ORIGIN_X,
                   ($urandom_range(4) == 0) ? 24'hFFF : 24'($urandom_range(4095)));
      set_register(tbgl_pkg::CSR_ORIGIN_Y,
                   ($urandom_range(4) == 0) ? 24'd0 : 24'($urandom_range(4095)));
      case ($urandom_range(5))
         0:       set_register(tbgl_pkg::CSR_BASE_COLOUR, 24'h000000);
         1:       set_register(tbgl_pkg::CSR_BASE_COLOUR, 24'hFFFFFF);
         default: set_register(tbgl_pkg::CSR_BASE_COLOUR, 24'($urandom));
      endcase
      set_register(tbgl_pkg::CSR_ESCAPE_BYTE,
                   ($urandom_range(3) == 0) ? 24'($urandom_range(255))
                                            : {16'd0, tbgl_pkg::RST_ESCAPE_BYTE});
   endtask

   // mostly well-formed text with escapes; some noise and stray string starts
   task automatic random_string();
      int len;
      int kind;
      int cmd;
      len = $urandom_range(1, 48);
      for (int i = 0; i < len; i++) begin
         kind = $urandom_range(99);
         if (kind < 65) begin
            send_byte(8'($urandom_range(8'h20, 8'hFF)), i == 0);
         end else if (kind < 73) begin
            send_byte(tbgl_pkg::CHAR_NEWLINE, i == 0);
         end else if (kind < 85) begin
            send_byte(box_cfg.escape_byte, i == 0);
            cmd = $urandom_range(9);
            if (cmd < 4) begin
               send_byte(tbgl_pkg::CMD_SET_RGB, 1'b0);
               repeat (3) send_byte(8'($urandom_range(255)), 1'b0);
            end else if (cmd < 7) begin
               send_byte(tbgl_pkg::CMD_BASE_COLOUR, 1'b0);
            end else begin
               send_byte(8'($urandom_range(255)), 1'b0);
            end
         end else if (kind < 92) begin
            send_byte(8'($urandom_range(8'h1F)), i == 0);
         end else begin
            send_byte(8'($urandom_range(255)), (i == 0) || ($urandom_range(9) == 0));
         end
      end
      if ($urandom_range(3) == 0) send_byte(tbgl_pkg::CHAR_NUL, 1'b0);
   endtask

   task automatic test_random_text();
      int target;
      for (int pass = 0; pass < 3; pass++) begin
         case (pass)
            0: begin tx_idle_pct = 30; rx_idle_pct = 62; end
            1: begin tx_idle_pct = 62; rx_idle_pct = 30; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         target = sent_items + RANDOM_ITEMS / 3;
         while (sent_items < target) begin
            wait_idle();
            random_setup();
            repeat ($urandom_range(1, 6)) random_string();
         end
      end
   endtask

   initial begin
      box_cfg     = '{tbgl_pkg::RST_BOX_COLUMNS, tbgl_pkg::RST_BOX_ROWS,
                      tbgl_pkg::RST_ORIGIN_X, tbgl_pkg::RST_ORIGIN_Y,
                      tbgl_pkg::RST_BASE_COLOUR, tbgl_pkg::RST_ESCAPE_BYTE};
      cur_column  = '0;
      cur_row     = '0;
      byte_total  = '0;
      string_done = 1'b0;
      esc_phase   = tbgl_pkg::ESC_NONE;
      held_red    = '0;
      held_green  = '0;
      cur_tint    = tbgl_pkg::RST_BASE_COLOUR;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_idle_pct = 30;
      rx_idle_pct = 62;
      test_printable_and_control();
      test_escape_sequences();
      test_box_edges();
      test_random_text();

      wait_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
